@@ rtl/core/hts_pkg.sv @@
// Shared types, constants and codes for the hit timing statistics block.
package hts_pkg;

  localparam int DEF_WINDOW     = 16;
  localparam int DEF_COUNT_BITS = 24;

  localparam int DEV_W   = 20;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W   = 24;
  localparam int SCORE_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_PERFECT_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT     = 2'd1;

  localparam logic [CFG_W-1:0] PERFECT_WINDOW_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MISS_LIMIT_RST     = 16'd4000;

  localparam logic [1:0] CLS_PERFECT = 2'd0;
  localparam logic [1:0] CLS_EARLY   = 2'd1;
  localparam logic [1:0] CLS_LATE    = 2'd2;
  localparam logic [1:0] CLS_NONE    = 2'd3;

  localparam logic [2:0] RANK_SP = 3'd0;
  localparam logic [2:0] RANK_S  = 3'd1;
  localparam logic [2:0] RANK_A  = 3'd2;
  localparam logic [2:0] RANK_B  = 3'd3;
  localparam logic [2:0] RANK_C  = 3'd4;
  localparam logic [2:0] RANK_D  = 3'd5;

  localparam int ACC_SCALE = 5000;
  localparam int THR_SP = 9800;
  localparam int THR_S  = 9500;
  localparam int THR_A  = 9000;
  localparam int THR_B  = 8000;
  localparam int THR_C  = 7000;
  localparam int STAB_FULL = 10000;

  typedef struct packed {
    logic                    req_type;
    logic signed [DEV_W-1:0] deviation;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              hit_class;
    logic                    is_miss;
    logic [CNT_W-1:0]        total_count;
    logic [CNT_W-1:0]        perfect_count;
    logic [CNT_W-1:0]        early_count;
    logic [CNT_W-1:0]        late_count;
    logic [CNT_W-1:0]        miss_count;
    logic [SCORE_W-1:0]      accuracy;
    logic [2:0]              rank_code;
    logic signed [DEV_W-1:0] window_mean;
    logic [SCORE_W-1:0]      stability;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] perfect_window;
    logic [CFG_W-1:0] miss_limit;
  } cfg_t;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic                    clr;
    logic signed [DEV_W-1:0] dev;
    logic [DEV_W-1:0]        mag;
    logic [1:0]              hit_class;
    logic                    is_miss;
  } hts_entry_t;

endpackage

@@ rtl/core/hit_timing_statistics.sv @@
// Top level of the hit timing statistics block.
//
//  channel | signals                         | direction | transaction
//  --------+---------------------------------+-----------+-----------------------------
//  in      | in_valid/in_ready, in_data      | in        | one hit or clear request
//  out     | out_valid/out_ready, out_data   | out       | statistics after the request
//  cfg     | cfg_valid/cfg_ready, cfg_index, | in        | register write, index 0
//          | cfg_data                        |           | perfect_window, 1 miss_limit
//
//  Each hit runs the back-end sequencer, whose time is set mostly by the shared
//  iterative divider, run up to three times. A clear request skips the window
//  update and the mean/stability.
//  Reset (rst_n low, synchronous) zeroes counters and window and restores the
//  register defaults 1000 and 4000; the ring RAM is not cleared.
//  The front queue takes two requests while the back end works; a stalled result
//  stays in the output register, and the back end holds its next result until it
//  is taken. cfg_ready is always high; writes to unknown indexes are dropped.
module hit_timing_statistics import hts_pkg::*; #(
  parameter int WINDOW     = DEF_WINDOW,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg_r;
  logic       q_valid, q_pop;
  hts_entry_t q_entry;

  assign cfg_ready = 1'b1;

  // Config registers; a write lands on every accepted cfg transaction to a known index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.perfect_window <= PERFECT_WINDOW_RST;
      cfg_r.miss_limit     <= MISS_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERFECT_WINDOW: cfg_r.perfect_window <= cfg_data;
        REG_MISS_LIMIT:     cfg_r.miss_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  hts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  hts_back #(.WINDOW(WINDOW), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/hts_ram.sv @@
// Generic single-port-write, registered-read RAM.
module hts_ram import hts_pkg::*; #(
  parameter int WIDTH = DEV_W,
  parameter int DEPTH = DEF_WINDOW,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hts_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module hts_div import hts_pkg::*; #(
  parameter int DW = 40,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dvd,
  input  logic [VW-1:0] dvs,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r;
  logic [VW-1:0] dvs_r;
  logic [VW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      dvs_r <= dvs;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? VW'(rem_sh - {1'b0, dvs_r}) : VW'(rem_sh);
      dvd_r <= {dvd_r[DW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/hts_isqrt.sv @@
// Iterative integer square root, two operand bits per cycle.
module hts_isqrt import hts_pkg::*; #(
  parameter int OW = 49,
  localparam int RW = (OW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [OW-1:0] op,
  output logic          done,
  output logic [RW-1:0] root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] op_r;
  logic [RW-1:0]   root_r;
  logic [RW+1:0]   rem_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic            fits;

  assign rem_sh = {rem_r, op_r[2*RW-1 -: 2]};
  assign trial  = {(RW+2)'(root_r), 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= (2*RW)'(op);
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      op_r   <= op_r << 2;
      rem_r  <= fits ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
      root_r <= RW'({root_r, fits});
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/core/hts_front.sv @@
// Front end: accepts transactions, classifies hits, two-entry queue to the back end.
module hts_front import hts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       q_valid,
  output hts_entry_t q_entry,
  input  logic       q_pop
);

  hts_entry_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  hts_entry_t ent;
  logic       push;

  always_comb begin
    ent.clr       = in_data.req_type;
    ent.dev       = in_data.deviation;
    ent.mag       = in_data.deviation[DEV_W-1] ? (~in_data.deviation + 1'b1)
                                               : in_data.deviation;
    ent.is_miss   = 1'b0;
    ent.hit_class = CLS_NONE;
    if (!in_data.req_type) begin
      ent.is_miss = ent.mag >= DEV_W'(cfg.miss_limit);
      if (ent.mag < DEV_W'(cfg.perfect_window)) begin
        ent.hit_class = CLS_PERFECT;
      end else if (in_data.deviation[DEV_W-1]) begin
        ent.hit_class = CLS_EARLY;
      end else begin
        ent.hit_class = CLS_LATE;
      end
    end
  end

  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_entry  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

endmodule

@@ rtl/core/hts_back.sv @@
// Back end: statistics update, window ring, accuracy/mean/stability sequencer.
module hts_back import hts_pkg::*; #(
  parameter int WINDOW     = DEF_WINDOW,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  hts_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int CB    = COUNT_BITS;
  localparam int HW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int NW    = $clog2(WINDOW + 1);
  localparam int SUM_W = DEV_W + NW;
  localparam int SQ_W  = 2*DEV_W - 1 + NW;
  localparam int SP_W  = SQ_W + NW;
  localparam int RT_W  = (SP_W + 1) / 2;
  localparam int PR_W  = 2*SUM_W;
  localparam int NUM_W = CB + 3;
  localparam int SC_W  = CB + 16;
  localparam int DV_A  = (SC_W > SUM_W) ? SC_W : SUM_W;
  localparam int DV_W  = (DV_A > RT_W) ? DV_A : RT_W;
  localparam int VR_W  = (CB > NW) ? CB : NW;
  localparam int KW    = $clog2(NW + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVICT  = 4'd1;
  localparam logic [3:0] S_NEW    = 4'd2;
  localparam logic [3:0] S_ADDSQ  = 4'd3;
  localparam logic [3:0] S_STATS  = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_ACCW   = 4'd6;
  localparam logic [3:0] S_MEAN   = 4'd7;
  localparam logic [3:0] S_MEANW  = 4'd8;
  localparam logic [3:0] S_SQ     = 4'd9;
  localparam logic [3:0] S_NSQ    = 4'd10;
  localparam logic [3:0] S_SQRT   = 4'd11;
  localparam logic [3:0] S_SQRTW  = 4'd12;
  localparam logic [3:0] S_SDW    = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]              state_r;
  hts_entry_t              it_r;
  logic [CB-1:0]           tot_r, per_r, ear_r, lat_r, mis_r;
  logic [HW-1:0]           head_r;
  logic [NW-1:0]           fill_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic [PR_W-1:0]         prod_r;
  logic [SP_W-1:0]         nsq_r;
  logic [KW-1:0]           kc_r;
  logic signed [NUM_W-1:0] num_r;
  logic [SCORE_W-1:0]      acc_r;
  logic [2:0]              rank_r;
  logic [DEV_W-1:0]        mean_r;
  logic [SCORE_W-1:0]      stab_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic [DEV_W-1:0]        ram_rdata;
  logic                    full;
  logic signed [DEV_W-1:0] old_dev;
  logic [DEV_W-1:0]        old_mag;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        mul_a;
  logic [SC_W-1:0]         scaled;
  logic [PR_W-1:0]         spread_w;
  logic [SP_W-1:0]         nsq_add;

  logic                    div_start, div_done;
  logic [DV_W-1:0]         div_dvd, div_quo;
  logic [VR_W-1:0]         div_dvs, div_rem;
  logic                    sqrt_start, sqrt_done;
  logic [RT_W-1:0]         root;
  logic                    rem_nz;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic rank_gt(input logic [DV_W-1:0] q, input logic nz, input int k);
    return (q > DV_W'(k)) || ((q == DV_W'(k)) && nz);
  endfunction

  assign full    = fill_r == NW'(WINDOW);
  assign old_dev = $signed(ram_rdata);
  assign old_mag = old_dev[DEV_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign scaled  = SC_W'(num_r) * SC_W'(ACC_SCALE);
  assign rem_nz  = div_rem != '0;
  assign nsq_add = ((fill_r >> kc_r) & NW'(1)) != '0 ? (SP_W'(sq_r) << kc_r) : '0;
  assign spread_w = (PR_W'(nsq_r) >= prod_r) ? PR_W'(nsq_r) - prod_r : '0;

  always_comb begin
    case (state_r)
      S_EVICT: mul_a = SUM_W'(old_mag);
      S_NEW:   mul_a = SUM_W'(it_r.mag);
      default: mul_a = sum_mag;
    endcase
  end

  // Shared divider: accuracy, window mean, then standard deviation.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = DV_W'(sum_mag);
    div_dvs   = VR_W'(fill_r);
    case (state_r)
      S_ACC: begin
        div_start = (tot_r != '0) && (num_r > 0);
        div_dvd   = DV_W'(scaled);
        div_dvs   = VR_W'(tot_r);
      end
      S_MEAN:  div_start = fill_r != '0;
      S_SQRTW: begin
        div_start = sqrt_done;
        div_dvd   = DV_W'(root);
      end
      default: div_start = 1'b0;
    endcase
  end

  assign sqrt_start = state_r == S_SQRT;
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  hts_ram #(.WIDTH(DEV_W), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (state_r == S_NEW),
    .waddr (head_r),
    .wdata (it_r.dev),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  hts_div #(.DW(DV_W), .VW(VR_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  hts_isqrt #(.OW(SP_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .op    (SP_W'(spread_w)),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tot_r       <= '0;
      per_r       <= '0;
      ear_r       <= '0;
      lat_r       <= '0;
      mis_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_entry.clr) begin
              tot_r   <= '0;
              per_r   <= '0;
              ear_r   <= '0;
              lat_r   <= '0;
              mis_r   <= '0;
              head_r  <= '0;
              fill_r  <= '0;
              sum_r   <= '0;
              sq_r    <= '0;
              state_r <= S_STATS;
            end else begin
              tot_r <= sat_inc(tot_r);
              if (q_entry.hit_class == CLS_PERFECT) per_r <= sat_inc(per_r);
              if (q_entry.hit_class == CLS_EARLY)   ear_r <= sat_inc(ear_r);
              if (q_entry.hit_class == CLS_LATE)    lat_r <= sat_inc(lat_r);
              if (q_entry.is_miss)                  mis_r <= sat_inc(mis_r);
              state_r <= S_EVICT;
            end
          end
        end
        S_EVICT: begin
          if (full) begin
            sum_r <= sum_r - SUM_W'(old_dev);
          end
          state_r <= S_NEW;
        end
        S_NEW: begin
          if (full) begin
            sq_r <= sq_r - SQ_W'(prod_r);
          end else begin
            fill_r <= fill_r + 1'b1;
          end
          sum_r   <= sum_r + SUM_W'(it_r.dev);
          head_r  <= (head_r == HW'(WINDOW - 1)) ? '0 : head_r + 1'b1;
          state_r <= S_ADDSQ;
        end
        S_ADDSQ: begin
          sq_r    <= sq_r + SQ_W'(prod_r);
          state_r <= S_STATS;
        end
        S_STATS: state_r <= S_ACC;
        S_ACC:   state_r <= div_start ? S_ACCW : S_MEAN;
        S_ACCW:  if (div_done) state_r <= S_MEAN;
        S_MEAN:  state_r <= div_start ? S_MEANW : S_DONE;
        S_MEANW: if (div_done) state_r <= S_SQ;
        S_SQ:    state_r <= S_NSQ;
        S_NSQ:   if (kc_r == KW'(NW - 1)) state_r <= S_SQRT;
        S_SQRT:  state_r <= S_SQRTW;
        S_SQRTW: if (sqrt_done) state_r <= S_SDW;
        S_SDW:   if (div_done) state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r <= q_entry;
    end
    if (state_r == S_EVICT || state_r == S_NEW || state_r == S_SQ) begin
      prod_r <= mul_a * mul_a;
    end
    if (state_r == S_STATS) begin
      num_r  <= NUM_W'({1'b0, per_r, 1'b0}) + NUM_W'({1'b0, ear_r})
              + NUM_W'({1'b0, lat_r}) - NUM_W'({1'b0, mis_r});
      acc_r  <= '0;
      rank_r <= RANK_D;
      mean_r <= '0;
      stab_r <= '0;
    end
    if (state_r == S_ACCW && div_done) begin
      acc_r <= SCORE_W'(div_quo);
      if (rank_gt(div_quo, rem_nz, THR_SP))      rank_r <= RANK_SP;
      else if (rank_gt(div_quo, rem_nz, THR_S))  rank_r <= RANK_S;
      else if (rank_gt(div_quo, rem_nz, THR_A))  rank_r <= RANK_A;
      else if (rank_gt(div_quo, rem_nz, THR_B))  rank_r <= RANK_B;
      else if (rank_gt(div_quo, rem_nz, THR_C))  rank_r <= RANK_C;
      else                                       rank_r <= RANK_D;
    end
    if (state_r == S_MEANW && div_done) begin
      mean_r <= sum_r[SUM_W-1] ? DEV_W'(-div_quo) : DEV_W'(div_quo);
    end
    if (state_r == S_SQ) begin
      nsq_r <= '0;
      kc_r  <= '0;
    end
    if (state_r == S_NSQ) begin
      nsq_r <= nsq_r + nsq_add;
      kc_r  <= kc_r + 1'b1;
    end
    if (state_r == S_SDW && div_done) begin
      stab_r <= (div_quo >= DV_W'(STAB_FULL / 2)) ? '0
              : SCORE_W'(STAB_FULL) - SCORE_W'({div_quo, 1'b0});
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.hit_class     <= it_r.clr ? CLS_NONE : it_r.hit_class;
      out_r.is_miss       <= !it_r.clr && it_r.is_miss;
      out_r.total_count   <= CNT_W'(tot_r);
      out_r.perfect_count <= CNT_W'(per_r);
      out_r.early_count   <= CNT_W'(ear_r);
      out_r.late_count    <= CNT_W'(lat_r);
      out_r.miss_count    <= CNT_W'(mis_r);
      out_r.accuracy      <= acc_r;
      out_r.rank_code     <= rank_r;
      out_r.window_mean   <= mean_r;
      out_r.stability     <= stab_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/sv/hit_timing_statistics_tb.sv @@
// Testbench for hit_timing_statistics: directed and random hits, live predictor, field checks.
`timescale 1ns / 100ps

module hit_timing_statistics_tb;
  import hts_pkg::*;

  localparam int RING_LEN   = 16;
  localparam int SAT_MAX    = (1 << CNT_W) - 1;
  localparam int SETTLE_CYC = 200;    // settle wait after draining, covers one request in the back end
  localparam int STALL_CYC  = 600;    // long receiver hold-off, fills the front queue
  localparam int WDOG_LIMIT = 20000;  // cycles with no transaction at all

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  hit_timing_statistics dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of registers, counters and the deviation window.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] pw_reg = PERFECT_WINDOW_RST;
  logic [CFG_W-1:0] ml_reg = MISS_LIMIT_RST;
  int unsigned      n_total, n_perfect, n_early, n_late, n_miss;
  longint           ring [RING_LEN];
  int unsigned      head, fill;
  longint           win_sum, win_sq;

  out_item_t        pending_stats[$];   // expected results, oldest first
  int               fails = 0;
  int               n_hits = 0, n_clears = 0, n_results = 0, n_cfg = 0;
  bit               hold_req = 1'b0;    // ask the receiver for a long hold-off
  bit               no_idle  = 1'b0;    // both sides run flat out

  function automatic int unsigned sat_bump(int unsigned c);
    return (c >= SAT_MAX) ? c : c + 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x    -= root + b;
        root  = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void wipe_stats();
    n_total = 0; n_perfect = 0; n_early = 0; n_late = 0; n_miss = 0;
    head = 0; fill = 0; win_sum = 0; win_sq = 0;
  endfunction

  // Updates the model with one accepted request and queues the statistics it yields.
  function automatic void score_hit(in_item_t req);
    out_item_t       r;
    longint          dev, mag, num, scaled, tot, spread;
    longint unsigned sd;
    r = '0;
    r.hit_class = CLS_NONE;
    r.rank_code = RANK_D;
    if (req.req_type) begin
      wipe_stats();
      n_clears++;
    end else begin
      dev = longint'(req.deviation);
      mag = (dev < 0) ? -dev : dev;
      n_total = sat_bump(n_total);
      if (mag < pw_reg) begin
        r.hit_class = CLS_PERFECT;
        n_perfect = sat_bump(n_perfect);
      end else if (dev < 0) begin
        r.hit_class = CLS_EARLY;
        n_early = sat_bump(n_early);
      end else begin
        r.hit_class = CLS_LATE;
        n_late = sat_bump(n_late);
      end
      if (mag >= ml_reg) begin
        r.is_miss = 1'b1;
        n_miss = sat_bump(n_miss);
      end
      // full window: oldest entry drops out before the new one goes in
      if (fill >= RING_LEN) begin
        win_sum -= ring[head];
        win_sq  -= ring[head] * ring[head];
      end else begin
        fill++;
      end
      ring[head] = dev;
      win_sum += dev;
      win_sq  += mag * mag;
      head = (head + 1) % RING_LEN;
      n_hits++;
    end

    tot = n_total;
    if (tot != 0) begin
      num = 2 * longint'(n_perfect) + n_early + n_late - longint'(n_miss);
      if (num > 0) begin
        scaled = num * ACC_SCALE;
        r.accuracy = SCORE_W'(scaled / tot);
        // rank uses the exact ratio, not the floored accuracy
        if (scaled > THR_SP * tot)     r.rank_code = RANK_SP;
        else if (scaled > THR_S * tot) r.rank_code = RANK_S;
        else if (scaled > THR_A * tot) r.rank_code = RANK_A;
        else if (scaled > THR_B * tot) r.rank_code = RANK_B;
        else if (scaled > THR_C * tot) r.rank_code = RANK_C;
      end
    end

    if (fill != 0) begin
      r.window_mean = DEV_W'(win_sum / longint'(fill));
      spread = longint'(fill) * win_sq - win_sum * win_sum;
      if (spread < 0) spread = 0;
      sd = int_sqrt(spread) / fill;
      r.stability = (2 * sd >= STAB_FULL) ? '0 : SCORE_W'(STAB_FULL - 2 * sd);
    end

    r.total_count   = CNT_W'(n_total);
    r.perfect_count = CNT_W'(n_perfect);
    r.early_count   = CNT_W'(n_early);
    r.late_count    = CNT_W'(n_late);
    r.miss_count    = CNT_W'(n_miss);
    pending_stats.insert(pending_stats.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_stats.size() == 0) begin
        $error("result with no request pending: %p", out_data);
        fails++;
      end else begin
        e = pending_stats[0];
        pending_stats.delete(0);
        if (out_data.hit_class !== e.hit_class) begin
          $error("hit_class exp %0d got %0d", e.hit_class, out_data.hit_class); fails++;
        end
        if (out_data.is_miss !== e.is_miss) begin
          $error("is_miss exp %0d got %0d", e.is_miss, out_data.is_miss); fails++;
        end
        if (out_data.total_count !== e.total_count) begin
          $error("total_count exp %0d got %0d", e.total_count, out_data.total_count); fails++;
        end
        if (out_data.perfect_count !== e.perfect_count) begin
          $error("perfect_count exp %0d got %0d", e.perfect_count, out_data.perfect_count);
          fails++;
        end
        if (out_data.early_count !== e.early_count) begin
          $error("early_count exp %0d got %0d", e.early_count, out_data.early_count); fails++;
        end
        if (out_data.late_count !== e.late_count) begin
          $error("late_count exp %0d got %0d", e.late_count, out_data.late_count); fails++;
        end
        if (out_data.miss_count !== e.miss_count) begin
          $error("miss_count exp %0d got %0d", e.miss_count, out_data.miss_count); fails++;
        end
        if (out_data.accuracy !== e.accuracy) begin
          $error("accuracy exp %0d got %0d", e.accuracy, out_data.accuracy); fails++;
        end
        if (out_data.rank_code !== e.rank_code) begin
          $error("rank_code exp %0d got %0d", e.rank_code, out_data.rank_code); fails++;
        end
        if (out_data.window_mean !== e.window_mean) begin
          $error("window_mean exp %0d got %0d", e.window_mean, out_data.window_mean); fails++;
        end
        if (out_data.stability !== e.stability) begin
          $error("stability exp %0d got %0d", e.stability, out_data.stability); fails++;
        end
      end
    end
  end

  // Watchdog: a stretch with no transaction on any channel means a hang.
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("[hit_timing_statistics] ERROR");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // Receiver: mostly ready, short and occasional long stalls, and the long
  // hold-off on request. Counts its own cycles.
  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (STALL_CYC) @(negedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 120)) @(negedge clk);
        end else begin
          out_ready <= (r < 75);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them run from and return to a falling edge.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // One request; valid stays up after acceptance unless a gap follows.
  task automatic send_req(input logic clr, input logic signed [DEV_W-1:0] dev);
    int gap;
    in_data.req_type  <= clr;
    in_data.deviation <= dev;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    score_hit(in_data);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_hit(input longint dev);
    send_req(1'b0, DEV_W'(dev));
  endtask

  // Input lowered, all results in, back end settled.
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PERFECT_WINDOW) pw_reg = val;
    else if (idx == REG_MISS_LIMIT) ml_reg = val;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_windows(input logic [CFG_W-1:0] pw, input logic [CFG_W-1:0] ml);
    drain();
    write_reg(REG_PERFECT_WINDOW, pw);
    write_reg(REG_MISS_LIMIT, ml);
  endtask

  // Random deviation biased toward the class and miss boundaries.
  function automatic longint pick_dev();
    int     r;
    longint m;
    r = $urandom_range(0, 99);
    if (r < 55)      m = $urandom_range(0, 2 * ml_reg + 200);
    else if (r < 80) m = (r < 68 ? longint'(pw_reg) : longint'(ml_reg)) + $urandom_range(0, 2) - 1;
    else             return longint'($signed(20'($urandom)));
    if (m < 0) m = 0;
    if (m > 524287) m = 524287;
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_defaults();
    send_req(1'b1, 20'sd0);           // clear with an empty window
    send_hit(0);
    send_hit(999);
    send_hit(-999);
    send_hit(1000);
    send_hit(-1000);
    send_hit(3999);
    send_hit(4000);
    send_hit(-4000);
    send_hit(524287);
    send_hit(-524288);
    send_req(1'b1, 20'sh5A5A5);       // deviation of a clear is ignored
    send_hit(1);
    send_hit(-1);
  endtask

  task automatic test_register_extremes();
    set_windows(16'd0, 16'd0);        // nothing perfect, everything a miss
    send_hit(0);
    send_hit(-5);
    send_hit(7);
    set_windows(16'hFFFF, 16'hFFFF);  // perfect below 65535, a miss from 65535 out
    send_hit(65534);
    send_hit(-65535);
    send_hit(65535);
    send_req(1'b1, 20'sd0);
    send_hit(-200000);
  endtask

  task automatic test_random_phase(input int count, input int clear_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < clear_pct) send_req(1'b1, DEV_W'($urandom));
      else send_hit(pick_dev());
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;                  // receiver stalls, sender keeps offering
    no_idle  = 1'b1;
    test_random_phase(20, 0);
    no_idle  = 1'b0;
    drain();                          // sender pauses until all results are back
    test_random_phase(30, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wipe_stats();
    @(negedge clk);

    test_directed_defaults();
    test_register_extremes();

    set_windows(PERFECT_WINDOW_RST, MISS_LIMIT_RST);
    test_random_phase(400, 3);
    no_idle = 1'b1;                   // a stretch with no idling on either side
    test_random_phase(100, 3);
    no_idle = 1'b0;
    set_windows(16'd0, 16'hFFFF);
    test_random_phase(200, 3);
    set_windows(16'hFFFF, 16'd0);
    test_random_phase(200, 3);
    set_windows(16'd200, 16'd500);
    test_random_phase(250, 3);
    set_windows(CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(1000, 9000)));
    test_random_phase(250, 3);
    test_backpressure();

    drain();
    $display("covered %0d hits, %0d clears, %0d register writes, %0d results checked",
             n_hits, n_clears, n_cfg, n_results);
    $display("includes class and miss boundaries, register extremes and a long output stall");
    if (fails == 0) begin
      $display("[hit_timing_statistics] OK");
    end else begin
      $display("[hit_timing_statistics] ERROR");
    end
    $finish;
  end

endmodule
